>>> rtl/core/tfp_pkg.sv
// Package for the typed frame parser: sizes, register indexes, frame lengths
// and the command/status types shared by the controller and the datapath.
// No dependencies.
package tfp_pkg;

    localparam int STATE_LEN = 19;

    localparam int BYTE_W  = 8;
    localparam int POS_W   = 5;
    localparam int DROP_W  = 32;
    localparam int LEN_W   = $clog2(STATE_LEN + 1);
    localparam int IDX_W   = $clog2(STATE_LEN);
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ROTARY   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GREETING = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CONTROL  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STATUS   = 3'd5;

    localparam logic [BYTE_W-1:0] SYNC_RST     = 8'd170;
    localparam logic [BYTE_W-1:0] BUTTON_RST   = 8'd1;
    localparam logic [BYTE_W-1:0] ROTARY_RST   = 8'd2;
    localparam logic [BYTE_W-1:0] GREETING_RST = 8'd3;
    localparam logic [BYTE_W-1:0] CONTROL_RST  = 8'd4;
    localparam logic [BYTE_W-1:0] STATUS_RST   = 8'd5;

    localparam logic [BYTE_W-1:0] BUTTON_LEN   = 8'd2;
    localparam logic [BYTE_W-1:0] ROTARY_LEN   = 8'd1;
    localparam logic [BYTE_W-1:0] GREETING_LEN = 8'd3;
    localparam logic [BYTE_W-1:0] CONTROL_LEN  = 8'd4;
    localparam logic [BYTE_W-1:0] STATUS_LEN   = BYTE_W'(STATE_LEN);
    localparam logic [BYTE_W-1:0] NO_LEN       = 8'd0;

    typedef struct packed {
        logic take_type;
        logic take_len;
        logic store_byte;
        logic drop;
        logic start_read;
        logic drain_step;
    } tfp_cmd_t;

    typedef struct packed {
        logic sync_hit;
        logic type_ok;
        logic len_ok;
        logic fill_done;
        logic xor_ok;
        logic rd_last;
        logic out_free;
    } tfp_stat_t;

endpackage

>>> rtl/core/tfp_ifs.sv
// Valid/ready channel interfaces of the typed frame parser: received bytes in,
// payload results out. Depends on tfp_pkg.
interface tfp_rx_if;
    logic                     valid;
    logic                     ready;
    logic [tfp_pkg::BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tfp_res_if;
    logic                      valid;
    logic                      ready;
    logic [tfp_pkg::BYTE_W-1:0] frame_kind;
    logic [tfp_pkg::BYTE_W-1:0] data_byte;
    logic [tfp_pkg::POS_W-1:0]  byte_position;
    logic [tfp_pkg::POS_W-1:0]  frame_length;
    logic                      last;
    logic [tfp_pkg::DROP_W-1:0] drop_total;

    modport source (output valid, output frame_kind, output data_byte,
                    output byte_position, output frame_length, output last,
                    output drop_total, input ready);
    modport sink   (input valid, input frame_kind, input data_byte,
                    input byte_position, input frame_length, input last,
                    input drop_total, output ready);
endinterface

>>> rtl/core/typed_frame_parser.sv
// Typed frame parser top level: tfp_ctrl plus tfp_dp. Depends on tfp_pkg, tfp_ifs.
// Received bytes are taken whenever rx is ready. After a good check byte is
// accepted, payload bytes pass the memory read register and then the result
// register, one result per cycle from the payload memory read port while results
// are not stalled; rx is not ready until the last result is loaded.
// Reset: config registers to defaults, hunting for sync, drop count zero.
module typed_frame_parser (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tfp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tfp_pkg::BYTE_W-1:0]    cfg_data,
    tfp_rx_if.sink                        rx,
    tfp_res_if.source                     res
);
    import tfp_pkg::*;

    tfp_cmd_t  cmd;
    tfp_stat_t stat;

    tfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_ready (rx.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    tfp_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rx_byte   (rx.rx_byte),
        .cmd       (cmd),
        .stat      (stat),
        .res       (res)
    );

endmodule

>>> rtl/core/tfp_ctrl.sv
// Frame parser controller: phase state machine, input handshake and drain
// sequencing. Depends on tfp_pkg; drives commands into tfp_dp.
module tfp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  tfp_pkg::tfp_stat_t stat,
    output tfp_pkg::tfp_cmd_t  cmd
);
    import tfp_pkg::*;

    localparam logic [2:0] ST_HUNT  = 3'd0;
    localparam logic [2:0] ST_TYPE  = 3'd1;
    localparam logic [2:0] ST_LEN   = 3'd2;
    localparam logic [2:0] ST_DATA  = 3'd3;
    localparam logic [2:0] ST_CHECK = 3'd4;
    localparam logic [2:0] ST_DRAIN = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       in_fire;

    assign in_ready = (state_reg != ST_DRAIN);
    assign in_fire  = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_HUNT:
            begin
                if (in_fire && stat.sync_hit)
                begin
                    state_next = ST_TYPE;
                end
            end
            ST_TYPE:
            begin
                if (in_fire)
                begin
                    if (stat.type_ok)
                    begin
                        cmd.take_type = 1'b1;
                        state_next    = ST_LEN;
                    end
                    else
                    begin
                        cmd.drop   = 1'b1;
                        state_next = stat.sync_hit ? ST_TYPE : ST_HUNT;
                    end
                end
            end
            ST_LEN:
            begin
                if (in_fire)
                begin
                    if (stat.len_ok)
                    begin
                        cmd.take_len = 1'b1;
                        state_next   = ST_DATA;
                    end
                    else
                    begin
                        cmd.drop   = 1'b1;
                        state_next = stat.sync_hit ? ST_TYPE : ST_HUNT;
                    end
                end
            end
            ST_DATA:
            begin
                if (in_fire)
                begin
                    cmd.store_byte = 1'b1;
                    if (stat.fill_done)
                    begin
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_CHECK:
            begin
                if (in_fire)
                begin
                    if (stat.xor_ok)
                    begin
                        cmd.start_read = 1'b1;
                        state_next     = ST_DRAIN;
                    end
                    else
                    begin
                        cmd.drop   = 1'b1;
                        state_next = ST_HUNT;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (stat.out_free)
                begin
                    cmd.drain_step = 1'b1;
                    if (stat.rd_last)
                    begin
                        state_next = ST_HUNT;
                    end
                end
            end
            default:
            begin
                state_next = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HUNT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

>>> rtl/core/tfp_dp.sv
// Frame parser datapath: config registers, type/length checks, running XOR,
// payload memory, drop counter and the result register. Depends on tfp_pkg,
// tfp_ifs; commanded by tfp_ctrl.
module tfp_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [tfp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tfp_pkg::BYTE_W-1:0]     cfg_data,
    input  logic [tfp_pkg::BYTE_W-1:0]     rx_byte,
    input  tfp_pkg::tfp_cmd_t              cmd,
    output tfp_pkg::tfp_stat_t             stat,
    tfp_res_if.source                      res
);
    import tfp_pkg::*;

    logic [BYTE_W-1:0] sync_reg;
    logic [BYTE_W-1:0] button_reg;
    logic [BYTE_W-1:0] rotary_reg;
    logic [BYTE_W-1:0] greeting_reg;
    logic [BYTE_W-1:0] control_reg;
    logic [BYTE_W-1:0] status_reg;

    logic [BYTE_W-1:0] held_type_reg;
    logic [LEN_W-1:0]  held_len_reg;
    logic [LEN_W-1:0]  fill_pos_reg;
    logic [BYTE_W-1:0] xor_reg;
    logic [DROP_W-1:0] drop_reg;

    logic [BYTE_W-1:0] payload_reg [STATE_LEN];
    logic [BYTE_W-1:0] rd_data_reg;
    logic [IDX_W-1:0]  rd_idx_reg;
    logic [IDX_W-1:0]  rd_idx_next;

    logic              out_valid_reg;
    logic [BYTE_W-1:0] out_kind_reg;
    logic [BYTE_W-1:0] out_data_reg;
    logic [POS_W-1:0]  out_pos_reg;
    logic [POS_W-1:0]  out_len_reg;
    logic              out_last_reg;
    logic [DROP_W-1:0] out_drop_reg;

    // first matching code in register order wins
    function automatic logic [BYTE_W-1:0] length_for(input logic [BYTE_W-1:0] t);
        logic [BYTE_W-1:0] len;
        len = NO_LEN;
        if (t == button_reg)
            len = BUTTON_LEN;
        else if (t == rotary_reg)
            len = ROTARY_LEN;
        else if (t == greeting_reg)
            len = GREETING_LEN;
        else if (t == control_reg)
            len = CONTROL_LEN;
        else if (t == status_reg)
            len = STATUS_LEN;
        return len;
    endfunction

    always_comb
    begin
        stat.sync_hit  = (rx_byte == sync_reg);
        stat.type_ok   = (length_for(rx_byte) != NO_LEN);
        stat.len_ok    = (rx_byte == length_for(held_type_reg));
        stat.fill_done = ((fill_pos_reg + LEN_W'(1)) >= held_len_reg);
        stat.xor_ok    = (rx_byte == xor_reg);
        stat.rd_last   = (LEN_W'(rd_idx_reg) + LEN_W'(1) == held_len_reg);
        stat.out_free  = !out_valid_reg || res.ready;
    end

    always_comb
    begin
        rd_idx_next = rd_idx_reg;
        if (cmd.start_read)
            rd_idx_next = '0;
        else if (cmd.drain_step && !stat.rd_last)
            rd_idx_next = rd_idx_reg + IDX_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_reg     <= SYNC_RST;
            button_reg   <= BUTTON_RST;
            rotary_reg   <= ROTARY_RST;
            greeting_reg <= GREETING_RST;
            control_reg  <= CONTROL_RST;
            status_reg   <= STATUS_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC:     sync_reg     <= cfg_data;
                REG_BUTTON:   button_reg   <= cfg_data;
                REG_ROTARY:   rotary_reg   <= cfg_data;
                REG_GREETING: greeting_reg <= cfg_data;
                REG_CONTROL:  control_reg  <= cfg_data;
                REG_STATUS:   status_reg   <= cfg_data;
                default:      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_type_reg <= '0;
            held_len_reg  <= '0;
            fill_pos_reg  <= '0;
            xor_reg       <= '0;
            drop_reg      <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.take_type)
                held_type_reg <= rx_byte;
            if (cmd.take_len)
            begin
                held_len_reg <= rx_byte[LEN_W-1:0];
                fill_pos_reg <= '0;
                xor_reg      <= held_type_reg ^ rx_byte;
            end
            if (cmd.store_byte)
            begin
                fill_pos_reg <= fill_pos_reg + LEN_W'(1);
                xor_reg      <= xor_reg ^ rx_byte;
            end
            if (cmd.drop)
                drop_reg <= drop_reg + DROP_W'(1);
            rd_idx_reg <= rd_idx_next;
            if (cmd.drain_step)
                out_valid_reg <= 1'b1;
            else if (res.ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte)
            payload_reg[fill_pos_reg[IDX_W-1:0]] <= rx_byte;
        rd_data_reg <= payload_reg[rd_idx_next];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.drain_step)
        begin
            out_kind_reg <= held_type_reg;
            out_data_reg <= rd_data_reg;
            out_pos_reg  <= POS_W'(rd_idx_reg);
            out_len_reg  <= POS_W'(held_len_reg);
            out_last_reg <= stat.rd_last;
            out_drop_reg <= drop_reg;
        end
    end

    assign res.valid         = out_valid_reg;
    assign res.frame_kind    = out_kind_reg;
    assign res.data_byte     = out_data_reg;
    assign res.byte_position = out_pos_reg;
    assign res.frame_length  = out_len_reg;
    assign res.last          = out_last_reg;
    assign res.drop_total    = out_drop_reg;

endmodule

>>> rtl/core/tfp_checker.sv
// Port-level checks for typed_frame_parser, attached by bind.
// Depends on tfp_pkg.
module tfp_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [tfp_pkg::BYTE_W-1:0]  frame_kind,
    input logic [tfp_pkg::BYTE_W-1:0]  data_byte,
    input logic [tfp_pkg::POS_W-1:0]   byte_position,
    input logic [tfp_pkg::POS_W-1:0]   frame_length,
    input logic                        last,
    input logic [tfp_pkg::DROP_W-1:0]  drop_total
);
    import tfp_pkg::*;

    // stalled transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte)
            && $stable(byte_position) && $stable(last))
        else $error("result changed while stalled");

    // no new byte taken while a frame is still draining
    a_no_rx_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last |-> !in_ready)
        else $error("rx ready during drain");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> byte_position == POS_W'(frame_length - POS_W'(1)))
        else $error("last flag on wrong position");

    // results of one frame come back to back with one drop count and type
    a_drain_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !last |=> out_valid && $stable(drop_total)
            && $stable(frame_kind)
            && byte_position == $past(byte_position) + POS_W'(1))
        else $error("broken result run");

endmodule

bind typed_frame_parser tfp_checker u_tfp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ready      (rx.ready),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .frame_kind    (res.frame_kind),
    .data_byte     (res.data_byte),
    .byte_position (res.byte_position),
    .frame_length  (res.frame_length),
    .last          (res.last),
    .drop_total    (res.drop_total)
);
